/* hw/rtl/hagl_pkg.sv */
// Package for the host admission greylist unit: table sizes, codes and shared types.
// Used by hagl_store, hagl_scan and host_admission_greylist_unit; depends on nothing.
package hagl_pkg;

  // Table depths.
  localparam int ALLOWED_ENTRIES = 16;
  localparam int BANNED_ENTRIES  = 16;
  localparam int GREY_ENTRIES    = 16;

  // Index widths per table; a single-entry table still gets one index bit.
  localparam int AL_IDX_W = (ALLOWED_ENTRIES > 1) ? $clog2(ALLOWED_ENTRIES) : 1;
  localparam int BN_IDX_W = (BANNED_ENTRIES > 1) ? $clog2(BANNED_ENTRIES) : 1;
  localparam int GR_IDX_W = (GREY_ENTRIES > 1) ? $clog2(GREY_ENTRIES) : 1;

  // The scanner walks the deepest table, so its index covers all three.
  localparam int MAX_ENTRIES_AB = (ALLOWED_ENTRIES > BANNED_ENTRIES) ?
                                  ALLOWED_ENTRIES : BANNED_ENTRIES;
  localparam int MAX_ENTRIES    = (MAX_ENTRIES_AB > GREY_ENTRIES) ?
                                  MAX_ENTRIES_AB : GREY_ENTRIES;
  localparam int IDX_W          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W          = $clog2(MAX_ENTRIES + 1);

  // Last index of each table as seen by the scan counter.
  localparam logic [CNT_W-1:0] AL_LAST = CNT_W'(ALLOWED_ENTRIES - 1);
  localparam logic [CNT_W-1:0] BN_LAST = CNT_W'(BANNED_ENTRIES - 1);
  localparam logic [CNT_W-1:0] GR_LAST = CNT_W'(GREY_ENTRIES - 1);

  // Field widths.
  localparam int ID_W      = 32;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 8;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // Register reset values and the count ceiling.
  localparam logic [TIME_W-1:0]  COOLDOWN_RESET = TIME_W'(1000);
  localparam logic [COUNT_W-1:0] RETRY_RESET    = COUNT_W'(10);
  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BAN   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_REG = 2'd2;

  // Table select codes.
  localparam logic [1:0] TBL_ALLOWED = 2'd0;
  localparam logic [1:0] TBL_BANNED  = 2'd1;
  localparam logic [1:0] TBL_GREY    = 2'd2;

  // One identifier slot as read by the scanner.
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } tbl_entry_t;

  // Outcome of one table scan.
  typedef struct packed {
    logic             done;
    logic             match_hit;
    logic [IDX_W-1:0] match_idx;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
  } scan_res_t;

  // Write requests from the sequencer to the table store.
  typedef struct packed {
    logic                tbl_we;
    logic [1:0]          tbl_sel;
    logic [IDX_W-1:0]    tbl_idx;
    logic [ID_W-1:0]     tbl_id;
    logic                gr_clr;
    logic                gr_data_we;
    logic [GR_IDX_W-1:0] gr_idx;
    logic [COUNT_W-1:0]  gr_cnt;
    logic [TIME_W-1:0]   gr_last;
  } store_wr_t;

endpackage

/* hw/rtl/hagl_store.sv */
// Register store for the allowed, banned and greylist tables with their valid bits.
// Depends on hagl_pkg.
module hagl_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  rd_sel,
  input  logic [hagl_pkg::IDX_W-1:0]  rd_idx,
  output hagl_pkg::tbl_entry_t        rd_entry,
  input  logic [hagl_pkg::GR_IDX_W-1:0] gr_rd_idx,
  output logic [hagl_pkg::COUNT_W-1:0]  gr_rd_cnt,
  output logic [hagl_pkg::TIME_W-1:0]   gr_rd_last,
  input  hagl_pkg::store_wr_t         wr
);
  import hagl_pkg::*;

  logic              al_valid_r [ALLOWED_ENTRIES];
  logic [ID_W-1:0]   al_id_r    [ALLOWED_ENTRIES];
  logic              bn_valid_r [BANNED_ENTRIES];
  logic [ID_W-1:0]   bn_id_r    [BANNED_ENTRIES];
  logic              gr_valid_r [GREY_ENTRIES];
  logic [ID_W-1:0]   gr_id_r    [GREY_ENTRIES];
  logic [COUNT_W-1:0] gr_cnt_r  [GREY_ENTRIES];
  logic [TIME_W-1:0]  gr_last_r [GREY_ENTRIES];

  // Valid bits: cleared at reset, set on insert, greylist bits cleared when a greylisted host is banned.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALLOWED_ENTRIES; i++) al_valid_r[i] <= 1'b0;
      for (int i = 0; i < BANNED_ENTRIES; i++) bn_valid_r[i] <= 1'b0;
      for (int i = 0; i < GREY_ENTRIES; i++) gr_valid_r[i] <= 1'b0;
    end else begin
      if (wr.tbl_we) begin
        case (wr.tbl_sel)
          TBL_ALLOWED: al_valid_r[wr.tbl_idx[AL_IDX_W-1:0]] <= 1'b1;
          TBL_BANNED:  bn_valid_r[wr.tbl_idx[BN_IDX_W-1:0]] <= 1'b1;
          TBL_GREY:    gr_valid_r[wr.tbl_idx[GR_IDX_W-1:0]] <= 1'b1;
          default: ;
        endcase
      end
      if (wr.gr_clr) begin
        gr_valid_r[wr.gr_idx] <= 1'b0;
      end
    end
  end

  // Identifiers and greylist contact data carry no reset.
  always_ff @(posedge clk) begin
    if (wr.tbl_we) begin
      case (wr.tbl_sel)
        TBL_ALLOWED: al_id_r[wr.tbl_idx[AL_IDX_W-1:0]] <= wr.tbl_id;
        TBL_BANNED:  bn_id_r[wr.tbl_idx[BN_IDX_W-1:0]] <= wr.tbl_id;
        TBL_GREY:    gr_id_r[wr.tbl_idx[GR_IDX_W-1:0]] <= wr.tbl_id;
        default: ;
      endcase
    end
    if (wr.gr_data_we) begin
      gr_cnt_r[wr.gr_idx]  <= wr.gr_cnt;
      gr_last_r[wr.gr_idx] <= wr.gr_last;
    end
  end

  // Scanner read port: one slot of the selected table.
  always_comb begin
    case (rd_sel)
      TBL_ALLOWED: begin
        rd_entry.valid = al_valid_r[rd_idx[AL_IDX_W-1:0]];
        rd_entry.id    = al_id_r[rd_idx[AL_IDX_W-1:0]];
      end
      TBL_BANNED: begin
        rd_entry.valid = bn_valid_r[rd_idx[BN_IDX_W-1:0]];
        rd_entry.id    = bn_id_r[rd_idx[BN_IDX_W-1:0]];
      end
      TBL_GREY: begin
        rd_entry.valid = gr_valid_r[rd_idx[GR_IDX_W-1:0]];
        rd_entry.id    = gr_id_r[rd_idx[GR_IDX_W-1:0]];
      end
      default: begin
        rd_entry.valid = 1'b0;
        rd_entry.id    = '0;
      end
    endcase
  end

  // Greylist contact data for the matched entry.
  assign gr_rd_cnt  = gr_cnt_r[gr_rd_idx];
  assign gr_rd_last = gr_last_r[gr_rd_idx];

endmodule

/* hw/rtl/hagl_scan.sv */
// Shared table scanner: one identifier compare per cycle, finds the first match and free slot.
// Depends on hagl_pkg; reads slots from hagl_store.
module hagl_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [1:0]                 sel,
  input  logic [hagl_pkg::ID_W-1:0]  key,
  output logic [1:0]                 rd_sel,
  output logic [hagl_pkg::IDX_W-1:0] rd_idx,
  input  hagl_pkg::tbl_entry_t       rd_entry,
  output hagl_pkg::scan_res_t        res
);
  import hagl_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic             match_hit_r, match_hit_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic             free_hit_r, free_hit_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0] last_idx;

  // Last slot of the table being walked.
  always_comb begin
    case (sel_r)
      TBL_ALLOWED: last_idx = AL_LAST;
      TBL_BANNED:  last_idx = BN_LAST;
      TBL_GREY:    last_idx = GR_LAST;
      default:     last_idx = '0;
    endcase
  end

  assign rd_sel = sel_r;
  assign rd_idx = cnt_r[IDX_W-1:0];

  // One slot per cycle; the first hit of each kind is kept.
  always_comb begin
    busy_nxt      = busy_r;
    done_nxt      = 1'b0;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    match_hit_nxt = match_hit_r;
    match_idx_nxt = match_idx_r;
    free_hit_nxt  = free_hit_r;
    free_idx_nxt  = free_idx_r;
    if (start) begin
      busy_nxt      = 1'b1;
      cnt_nxt       = '0;
      sel_nxt       = sel;
      match_hit_nxt = 1'b0;
      free_hit_nxt  = 1'b0;
    end else if (busy_r) begin
      if (rd_entry.valid && (rd_entry.id == key) && !match_hit_r) begin
        match_hit_nxt = 1'b1;
        match_idx_nxt = cnt_r[IDX_W-1:0];
      end
      if (!rd_entry.valid && !free_hit_r) begin
        free_hit_nxt = 1'b1;
        free_idx_nxt = cnt_r[IDX_W-1:0];
      end
      if (cnt_r == last_idx) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Scan position and findings.
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    sel_r       <= sel_nxt;
    match_hit_r <= match_hit_nxt;
    match_idx_r <= match_idx_nxt;
    free_hit_r  <= free_hit_nxt;
    free_idx_r  <= free_idx_nxt;
  end

  assign res.done      = done_r;
  assign res.match_hit = match_hit_r;
  assign res.match_idx = match_idx_r;
  assign res.free_hit  = free_hit_r;
  assign res.free_idx  = free_idx_r;

endmodule

/* hw/rtl/host_admission_greylist_unit.sv */
// Top level of the host admission greylist unit: request sequencer and configuration registers.
// Depends on hagl_pkg, hagl_store and hagl_scan.
//
//   Channel | Direction | Handshake          | Word
//   in_     | input     | in_valid/in_stall   | mode, host_id, now_ms
//   out_    | output    | out_valid/out_stall | accepted, newly_added, table_full
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each table scan walks every slot of its table through the single shared scanner.
// An add or ban scans one table; a check walks up to three tables: allowed, banned and grey.
// Reset empties all three tables and loads the register defaults; no clearing pass is needed.
// A new word is taken while a finished result still waits at the output; the sequencer then
// holds its next result until out_stall falls.
module host_admission_greylist_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hagl_pkg::MODE_W-1:0]     in_mode,
  input  logic [hagl_pkg::ID_W-1:0]       in_host_id,
  input  logic [hagl_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accepted,
  output logic                            out_newly_added,
  output logic                            out_table_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hagl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hagl_pkg::CFG_W-1:0]      cfg_data
);
  import hagl_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SCAN_TGT  = 3'd1;
  localparam logic [2:0] ST_SCAN_AL   = 3'd2;
  localparam logic [2:0] ST_SCAN_BN   = 3'd3;
  localparam logic [2:0] ST_SCAN_GR   = 3'd4;
  localparam logic [2:0] ST_GREY_EVAL = 3'd5;
  localparam logic [2:0] ST_FINISH    = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic                acc_r, acc_nxt;
  logic                add_r, add_nxt;
  logic                full_r, full_nxt;
  logic                bn_free_hit_r, bn_free_hit_nxt;
  logic [IDX_W-1:0]    bn_free_idx_r, bn_free_idx_nxt;
  logic [GR_IDX_W-1:0] gr_idx_r, gr_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_acc_r, out_acc_nxt;
  logic                out_add_r, out_add_nxt;
  logic                out_full_r, out_full_nxt;
  logic [TIME_W-1:0]   cooldown_r;
  logic [COUNT_W-1:0]  retry_r;
  logic                self_reg_r;

  logic                scan_start;
  logic [1:0]          scan_sel;
  logic [1:0]          rd_sel;
  logic [IDX_W-1:0]    rd_idx;
  tbl_entry_t          rd_entry;
  scan_res_t           scan_res;
  store_wr_t           wr;
  logic [COUNT_W-1:0]  gr_cnt;
  logic [TIME_W-1:0]   gr_last;
  logic [TIME_W-1:0]   elapsed;

  hagl_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_sel     (rd_sel),
    .rd_idx     (rd_idx),
    .rd_entry   (rd_entry),
    .gr_rd_idx  (gr_idx_r),
    .gr_rd_cnt  (gr_cnt),
    .gr_rd_last (gr_last),
    .wr         (wr)
  );

  hagl_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .sel      (scan_sel),
    .key      (id_r),
    .rd_sel   (rd_sel),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .res      (scan_res)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign elapsed   = now_r - gr_last;

  // Request sequencer.
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    id_nxt          = id_r;
    now_nxt         = now_r;
    acc_nxt         = acc_r;
    add_nxt         = add_r;
    full_nxt        = full_r;
    bn_free_hit_nxt = bn_free_hit_r;
    bn_free_idx_nxt = bn_free_idx_r;
    gr_idx_nxt      = gr_idx_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_acc_nxt     = out_acc_r;
    out_add_nxt     = out_add_r;
    out_full_nxt    = out_full_r;
    scan_start      = 1'b0;
    scan_sel        = TBL_ALLOWED;
    wr              = '0;
    wr.tbl_id       = id_r;
    wr.gr_idx       = gr_idx_r;
    wr.gr_last      = now_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode;
          id_nxt   = in_host_id;
          now_nxt  = in_now_ms;
          acc_nxt  = 1'b0;
          add_nxt  = 1'b0;
          full_nxt = 1'b0;
          case (in_mode)
            MODE_CHECK: begin
              scan_start = 1'b1;
              scan_sel   = TBL_ALLOWED;
              state_nxt  = ST_SCAN_AL;
            end
            MODE_ALLOW: begin
              scan_start = 1'b1;
              scan_sel   = TBL_ALLOWED;
              state_nxt  = ST_SCAN_TGT;
            end
            MODE_BAN: begin
              scan_start = 1'b1;
              scan_sel   = TBL_BANNED;
              state_nxt  = ST_SCAN_TGT;
            end
            default: state_nxt = ST_FINISH;
          endcase
        end
      end

      // Add or ban: insert unless already present.
      ST_SCAN_TGT: begin
        if (scan_res.done) begin
          if (!scan_res.match_hit) begin
            if (scan_res.free_hit) begin
              wr.tbl_we  = 1'b1;
              wr.tbl_sel = (mode_r == MODE_ALLOW) ? TBL_ALLOWED : TBL_BANNED;
              wr.tbl_idx = scan_res.free_idx;
              add_nxt    = 1'b1;
            end else begin
              full_nxt = 1'b1;
            end
          end
          state_nxt = ST_FINISH;
        end
      end

      // Check: allowed hosts pass at once.
      ST_SCAN_AL: begin
        if (scan_res.done) begin
          if (scan_res.match_hit) begin
            acc_nxt   = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            scan_start = 1'b1;
            scan_sel   = TBL_BANNED;
            state_nxt  = ST_SCAN_BN;
          end
        end
      end

      // Check: reject banned hosts, or all if self_reg is off; keep the free slot for a ban.
      ST_SCAN_BN: begin
        if (scan_res.done) begin
          bn_free_hit_nxt = scan_res.free_hit;
          bn_free_idx_nxt = scan_res.free_idx;
          if (scan_res.match_hit || !self_reg_r) begin
            state_nxt = ST_FINISH;
          end else begin
            scan_start = 1'b1;
            scan_sel   = TBL_GREY;
            state_nxt  = ST_SCAN_GR;
          end
        end
      end

      // Check: greylist lookup, entering unknown hosts where there is room.
      ST_SCAN_GR: begin
        if (scan_res.done) begin
          if (scan_res.match_hit) begin
            gr_idx_nxt = scan_res.match_idx[GR_IDX_W-1:0];
            state_nxt  = ST_GREY_EVAL;
          end else begin
            if (scan_res.free_hit) begin
              wr.tbl_we     = 1'b1;
              wr.tbl_sel    = TBL_GREY;
              wr.tbl_idx    = scan_res.free_idx;
              wr.gr_data_we = 1'b1;
              wr.gr_idx     = scan_res.free_idx[GR_IDX_W-1:0];
              wr.gr_cnt     = '0;
            end else begin
              full_nxt = 1'b1;
            end
            acc_nxt   = 1'b1;
            state_nxt = ST_FINISH;
          end
        end
      end

      // Greylisted host: ban past the retry limit, else admit once the cooldown has passed.
      ST_GREY_EVAL: begin
        if (gr_cnt > retry_r) begin
          if (bn_free_hit_r) begin
            wr.tbl_we  = 1'b1;
            wr.tbl_sel = TBL_BANNED;
            wr.tbl_idx = bn_free_idx_r;
            wr.gr_clr  = 1'b1;
          end else begin
            full_nxt = 1'b1;
          end
        end else if (elapsed > cooldown_r) begin
          wr.gr_data_we = 1'b1;
          wr.gr_cnt     = (gr_cnt == COUNT_MAX) ? gr_cnt : gr_cnt + COUNT_W'(1);
          acc_nxt       = 1'b1;
        end
        state_nxt = ST_FINISH;
      end

      // Hand the result to the output register once it is free.
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc_r;
          out_add_nxt   = add_r;
          out_full_nxt  = full_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Word and result holding registers.
  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    id_r          <= id_nxt;
    now_r         <= now_nxt;
    acc_r         <= acc_nxt;
    add_r         <= add_nxt;
    full_r        <= full_nxt;
    bn_free_hit_r <= bn_free_hit_nxt;
    bn_free_idx_r <= bn_free_idx_nxt;
    gr_idx_r      <= gr_idx_nxt;
    out_acc_r     <= out_acc_nxt;
    out_add_r     <= out_add_nxt;
    out_full_r    <= out_full_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooldown_r <= COOLDOWN_RESET;
      retry_r    <= RETRY_RESET;
      self_reg_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COOLDOWN: cooldown_r <= cfg_data[TIME_W-1:0];
        CFG_RETRY:    retry_r    <= cfg_data[COUNT_W-1:0];
        CFG_SELF_REG: self_reg_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_newly_added = out_add_r;
  assign out_table_full  = out_full_r;

endmodule

/* test/host_admission_checker.sv */
`timescale 1ns / 100ps
// Result checker for host_admission_greylist_unit: keeps its own copy of the three host
// tables and the registers, predicts each result word and compares it as it leaves.
// Depends on hagl_pkg only.
module host_admission_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [hagl_pkg::MODE_W-1:0]    in_mode,
  input  logic [hagl_pkg::ID_W-1:0]      in_host_id,
  input  logic [hagl_pkg::TIME_W-1:0]    in_now_ms,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_accepted,
  input  logic                           out_newly_added,
  input  logic                           out_table_full,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [hagl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hagl_pkg::CFG_W-1:0]     cfg_data,
  output int                             pending,
  output int                             fail_count,
  output int                             checked_count,
  output int                             admit_count
);
  import hagl_pkg::*;

  typedef struct packed {
    logic accepted;
    logic newly_added;
    logic table_full;
  } verdict_t;

  // Shadow tables, indexed by the package's table select codes.
  logic               slot_v    [3][MAX_ENTRIES];
  logic [ID_W-1:0]    slot_id   [3][MAX_ENTRIES];
  logic [COUNT_W-1:0] grey_cnt  [GREY_ENTRIES];
  logic [TIME_W-1:0]  grey_last [GREY_ENTRIES];

  // Shadow registers.
  logic [TIME_W-1:0]  cooldown;
  logic [COUNT_W-1:0] retry_cap;
  logic               self_reg;

  verdict_t verdict_q[$];
  int       fails;
  int       checked;
  int       admits;

  function automatic int depth_of(logic [1:0] tbl);
    case (tbl)
      TBL_ALLOWED: return ALLOWED_ENTRIES;
      TBL_BANNED:  return BANNED_ENTRIES;
      default:     return GREY_ENTRIES;
    endcase
  endfunction

  function automatic int find_host(logic [1:0] tbl, logic [ID_W-1:0] id);
    for (int i = 0; i < depth_of(tbl); i++)
      if (slot_v[tbl][i] && slot_id[tbl][i] == id) return i;
    return -1;
  endfunction

  // Lowest free slot, or -1 when the table is full.
  function automatic int free_slot(logic [1:0] tbl);
    for (int i = 0; i < depth_of(tbl); i++)
      if (!slot_v[tbl][i]) return i;
    return -1;
  endfunction

  // Add or ban request: insert the host unless it is already present.
  function automatic verdict_t enrol_host(logic [1:0] tbl, logic [ID_W-1:0] id);
    verdict_t v;
    int       s;
    v = '0;
    if (find_host(tbl, id) < 0) begin
      s = free_slot(tbl);
      if (s < 0) begin
        v.table_full = 1'b1;
      end else begin
        slot_v[tbl][s]  = 1'b1;
        slot_id[tbl][s] = id;
        v.newly_added   = 1'b1;
      end
    end
    return v;
  endfunction

  // Connection attempt: allowed, banned, then the greylist rules.
  function automatic verdict_t check_attempt(logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
    verdict_t          v;
    int                g;
    int                b;
    logic [TIME_W-1:0] elapsed;
    v = '0;
    if (find_host(TBL_ALLOWED, id) >= 0) begin
      v.accepted = 1'b1;
    end else if (find_host(TBL_BANNED, id) < 0 && self_reg) begin
      g = find_host(TBL_GREY, id);
      if (g < 0) begin
        // An unknown host is admitted even when the greylist has no room for it.
        g = free_slot(TBL_GREY);
        if (g < 0) begin
          v.table_full = 1'b1;
        end else begin
          slot_v[TBL_GREY][g]  = 1'b1;
          slot_id[TBL_GREY][g] = id;
          grey_cnt[g]          = '0;
          grey_last[g]         = now;
        end
        v.accepted = 1'b1;
      end else if (grey_cnt[g] > retry_cap) begin
        // Too many contacts: move to the banned table if it has room.
        b = free_slot(TBL_BANNED);
        if (b < 0) begin
          v.table_full = 1'b1;
        end else begin
          slot_v[TBL_BANNED][b]  = 1'b1;
          slot_id[TBL_BANNED][b] = id;
          slot_v[TBL_GREY][g]    = 1'b0;
        end
      end else begin
        elapsed = now - grey_last[g];
        if (elapsed > cooldown) begin
          grey_last[g] = now;
          if (grey_cnt[g] != COUNT_MAX) grey_cnt[g] = grey_cnt[g] + COUNT_W'(1);
          v.accepted = 1'b1;
        end
      end
    end
    return v;
  endfunction

  function automatic verdict_t admission_verdict(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                                 logic [TIME_W-1:0] now);
    case (mode)
      MODE_CHECK: return check_attempt(id, now);
      MODE_ALLOW: return enrol_host(TBL_ALLOWED, id);
      MODE_BAN:   return enrol_host(TBL_BANNED, id);
      default:    return '0;
    endcase
  endfunction

  task automatic compare_bit(string field, logic want, logic got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch on result %0d: expected %b, got %b",
               $time, field, checked, want, got);
    end
  endtask

  // Everything is sampled at the rising edge, so the values seen are those the block saw.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      for (int t = 0; t < 3; t++)
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          slot_v[t][i]  = 1'b0;
          slot_id[t][i] = '0;
        end
      for (int i = 0; i < GREY_ENTRIES; i++) begin
        grey_cnt[i]  = '0;
        grey_last[i] = '0;
      end
      cooldown  = COOLDOWN_RESET;
      retry_cap = RETRY_RESET;
      self_reg  = 1'b0;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COOLDOWN: cooldown  = cfg_data[TIME_W-1:0];
          CFG_RETRY:    retry_cap = cfg_data[COUNT_W-1:0];
          CFG_SELF_REG: self_reg  = cfg_data[0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall)
        verdict_q = {verdict_q, admission_verdict(in_mode, in_host_id, in_now_ms)};

      // Each result word is held against the oldest outstanding prediction.
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          fails++;
          $display("%0t: result word with no request outstanding:", $time);
          $display("  accepted %b newly_added %b table_full %b",
                   out_accepted, out_newly_added, out_table_full);
        end else begin
          want = verdict_q.pop_front();
          compare_bit("accepted", want.accepted, out_accepted);
          compare_bit("newly_added", want.newly_added, out_newly_added);
          compare_bit("table_full", want.table_full, out_table_full);
          if (want.accepted) admits++;
        end
        checked++;
      end
    end
    pending       <= verdict_q.size();
    fail_count    <= fails;
    checked_count <= checked;
    admit_count   <= admits;
  end

endmodule

/* test/host_admission_greylist_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench top for host_admission_greylist_unit: drives requests and register writes with
// random idling and back-pressure, and reports the verdict from host_admission_checker.
// Depends on hagl_pkg, the block itself and test/host_admission_checker.sv.
module host_admission_greylist_unit_tb;
  import hagl_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int SAT_CONTACTS   = 260;

  // Mode and register index that the block does not use.
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    in_mode    = MODE_CHECK;
  logic [ID_W-1:0]      in_host_id = '0;
  logic [TIME_W-1:0]    in_now_ms  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_accepted;
  logic                 out_newly_added;
  logic                 out_table_full;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COOLDOWN;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int pending;
  int fail_count;
  int checked_count;
  int admit_count;

  logic              calm = 1'b0;
  int                items_sent;
  int                reg_writes;
  int                stall_run;
  int                quiet_cycles;
  logic [ID_W-1:0]   hosts[$];
  logic [TIME_W-1:0] clock_ms;
  logic [ID_W-1:0]   sat_host;

  host_admission_greylist_unit i_dut (.*);

  host_admission_checker i_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_host_id, .in_now_ms,
    .out_valid, .out_stall, .out_accepted, .out_newly_added, .out_table_full,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .pending, .fail_count, .checked_count, .admit_count
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one; none at all while calm.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Result back-pressure: runs of random length, each one stalled or not at random.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_run <= idle_len();
    end
  end

  // Watchdog: too long without any word moving on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request word and hold it until taken; valid stays high if no gap follows.
  task automatic send_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                              logic [TIME_W-1:0] now);
    int gap;
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_host_id <= id;
    in_now_ms  <= now;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every result word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write the three registers back to back, junk in unused bits; may poke CFG_UNUSED first.
  task automatic configure(logic [TIME_W-1:0] cool, logic [COUNT_W-1:0] retry, logic sreg,
                           logic poke_unused);
    logic [CFG_IDX_W-1:0] idx[$];
    logic [CFG_W-1:0]     val[$];
    idx = '{CFG_COOLDOWN, CFG_RETRY, CFG_SELF_REG};
    val = '{cool, ($urandom() & ~32'hFF) | CFG_W'(retry), ($urandom() & ~32'h1) | CFG_W'(sreg)};
    if (poke_unused) begin
      idx.push_front(CFG_UNUSED);
      val.push_front($urandom());
    end
    drain();
    foreach (idx[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ID_W-1:0] pick_host();
    if ($urandom_range(0, 99) < 85) return hosts[$urandom_range(0, hosts.size() - 1)];
    return $urandom();
  endfunction

  // Random traffic over a fresh small pool of hosts so that hosts come back again and again.
  task automatic random_phase(int n, logic [TIME_W-1:0] max_step, int pool_n);
    logic [MODE_W-1:0] mode;
    int                r;
    hosts.delete();
    repeat (pool_n) hosts = {hosts, ID_W'($urandom())};
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 80)      mode = MODE_CHECK;
      else if (r < 87) mode = MODE_ALLOW;
      else if (r < 94) mode = MODE_BAN;
      else             mode = MODE_UNUSED;
      if ($urandom_range(0, 29) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, max_step);
      if ($urandom_range(0, 39) == 0) calm <= !calm;
      send_request(mode, pick_host(), clock_ms);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: unknown hosts are turned away, add and ban with duplicates.
    send_request(MODE_CHECK, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_ALLOW, 32'h0000_0000, 32'h0000_0001);
    send_request(MODE_ALLOW, 32'h0000_0000, 32'h0000_0002);
    send_request(MODE_BAN, 32'hFFFF_FFFF, 32'h0000_0003);
    send_request(MODE_BAN, 32'hFFFF_FFFF, 32'h0000_0004);
    send_request(MODE_CHECK, 32'h0000_0000, 32'h0000_0005);
    send_request(MODE_CHECK, 32'hFFFF_FFFF, 32'h0000_0006);

    // Greylist walk: cooldown edge, two contacts, then a ban once the count passes the limit.
    configure(32'd5, 8'd1, 1'b1, 1'b0);
    send_request(MODE_CHECK, 32'h1234_5678, 32'd100);
    send_request(MODE_CHECK, 32'h1234_5678, 32'd103);
    send_request(MODE_CHECK, 32'h1234_5678, 32'd105);
    send_request(MODE_CHECK, 32'h1234_5678, 32'd106);
    send_request(MODE_CHECK, 32'h1234_5678, 32'd200);
    send_request(MODE_CHECK, 32'h1234_5678, 32'd300);
    send_request(MODE_CHECK, 32'h1234_5678, 32'd400);
    // Elapsed time across the wrap of the millisecond counter.
    send_request(MODE_CHECK, 32'hA5A5_A5A5, 32'hFFFF_FFF0);
    send_request(MODE_CHECK, 32'hA5A5_A5A5, 32'h0000_0010);
    // Banning a greylisted host directly; the banned table wins from then on.
    send_request(MODE_BAN, 32'hA5A5_A5A5, 32'h0000_0020);
    send_request(MODE_CHECK, 32'hA5A5_A5A5, 32'h0000_0030);

    // Count saturation: one host contacted until its count sticks at the ceiling,
    // then a lower limit shows the count did not wrap.
    configure(32'd0, 8'd255, 1'b1, 1'b0);
    sat_host = $urandom();
    clock_ms = $urandom();
    repeat (SAT_CONTACTS) begin
      clock_ms = clock_ms + $urandom_range(1, 3);
      send_request(MODE_CHECK, sat_host, clock_ms);
    end
    configure(32'd0, 8'd254, 1'b1, 1'b0);
    send_request(MODE_CHECK, sat_host, clock_ms + 1);

    // Random phases through a spread of settings, extremes included.
    configure(32'd1000, 8'd10, 1'b0, 1'b0);
    random_phase(60, 32'd2000, 12);
    configure(TIME_W'($urandom_range(0, 50)), COUNT_W'($urandom_range(0, 3)), 1'b1, 1'b1);
    random_phase(130, 32'd60, 10);
    configure(32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0);
    random_phase(50, 32'hFFFF_FFFF, 8);
    configure($urandom(), COUNT_W'($urandom_range(0, 255)), 1'b1, 1'b0);
    random_phase(60, 32'h8000_0000, 10);
    configure(32'd0, 8'd0, 1'b1, 1'b0);
    random_phase(70, 32'd4, 8);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d request words and %0d register writes: defaults, greylist cooldown,",
             items_sent, reg_writes);
    $display("count saturation and random traffic; %0d results checked, %0d admissions.",
             checked_count, admit_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
